// File: src/trs_pkg.sv
package trs_pkg;

	localparam int QW     = 16;
	localparam int SHW    = 32;
	localparam int PROD_W = 2 * QW;
	localparam int ROT_W  = PROD_W + 2;
	localparam int MUL_W  = ROT_W + QW;
	localparam int OUT_W  = 32;
	localparam int FRAC_DROP = 20;
	localparam int N_ROT  = 9;

	localparam logic signed [ROT_W-1:0] ONE_Q28  = ROT_W'(64'sd1 <<< 28);
	localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(64'sd1 <<< (FRAC_DROP - 1));

	typedef logic signed [QW-1:0]     q_t;
	typedef logic signed [SHW-1:0]    sh_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [MUL_W-1:0]  mul_t;

	typedef struct packed {
		q_t  quat_x;
		q_t  quat_y;
		q_t  quat_z;
		q_t  quat_w;
		q_t  scale_x;
		q_t  scale_y;
		q_t  scale_z;
		sh_t shift_x;
		sh_t shift_y;
		sh_t shift_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_r0c0;
		logic signed [OUT_W-1:0] out_r0c1;
		logic signed [OUT_W-1:0] out_r0c2;
		logic signed [OUT_W-1:0] out_r0c3;
		logic signed [OUT_W-1:0] out_r1c0;
		logic signed [OUT_W-1:0] out_r1c1;
		logic signed [OUT_W-1:0] out_r1c2;
		logic signed [OUT_W-1:0] out_r1c3;
		logic signed [OUT_W-1:0] out_r2c0;
		logic signed [OUT_W-1:0] out_r2c1;
		logic signed [OUT_W-1:0] out_r2c2;
		logic signed [OUT_W-1:0] out_r2c3;
	} out_beat_t;

	// half products x*y etc; doubling happens in stage 2
	typedef struct packed {
		prod_t xx;
		prod_t yy;
		prod_t zz;
		prod_t xy;
		prod_t xz;
		prod_t yz;
		prod_t wx;
		prod_t wy;
		prod_t wz;
		q_t [2:0]  scale;
		sh_t [2:0] shift;
	} s1_t;

	// rot[3*row + col], Q.28
	typedef struct packed {
		rot_t [N_ROT-1:0] rot;
		q_t [2:0]         scale;
		sh_t [2:0]        shift;
	} s2_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ld_t;

endpackage

// File: src/trs_in_if.sv
interface trs_in_if import trs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/trs_out_if.sv
interface trs_out_if import trs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/trs_pipe_ctl.sv
module trs_pipe_ctl import trs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pipe_ld_t ld
);

	logic v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		ld.ld_s4 = !v_s4 || out_ready;
		ld.ld_s3 = !v_s3 || ld.ld_s4;
		ld.ld_s2 = !v_s2 || ld.ld_s3;
		ld.ld_s1 = !v_s1 || ld.ld_s2;
	end

	assign in_ready  = ld.ld_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld.ld_s1) v_s1 <= in_valid;
			if (ld.ld_s2) v_s2 <= v_s1;
			if (ld.ld_s3) v_s3 <= v_s2;
			if (ld.ld_s4) v_s4 <= v_s3;
		end
	end

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !out_ready) |-> !in_ready)
		else $error("input ready while pipe full and stalled");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat missing from stage 1");

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ld.ld_s4) |=> v_s3)
		else $error("stage 3 beat dropped under stall");

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones({v_s1, v_s2, v_s3, v_s4}) ==
			$countones($past({v_s1, v_s2, v_s3, v_s4}))
			+ $past(in_valid && in_ready) - $past(out_valid && out_ready)))
		else $error("beats in flight not conserved");

endmodule

// File: src/trs_quat_prod.sv
module trs_quat_prod import trs_pkg::*; (
	input  logic     clk,
	input  logic     ld,
	input  in_beat_t d,
	output s1_t      q
);

	s1_t stg_s1;

	always_ff @(posedge clk) begin
		if (ld) begin
			stg_s1.xx    <= d.quat_x * d.quat_x;
			stg_s1.yy    <= d.quat_y * d.quat_y;
			stg_s1.zz    <= d.quat_z * d.quat_z;
			stg_s1.xy    <= d.quat_x * d.quat_y;
			stg_s1.xz    <= d.quat_x * d.quat_z;
			stg_s1.yz    <= d.quat_y * d.quat_z;
			stg_s1.wx    <= d.quat_w * d.quat_x;
			stg_s1.wy    <= d.quat_w * d.quat_y;
			stg_s1.wz    <= d.quat_w * d.quat_z;
			stg_s1.scale <= {d.scale_z, d.scale_y, d.scale_x};
			stg_s1.shift <= {d.shift_z, d.shift_y, d.shift_x};
		end
	end

	assign q = stg_s1;

endmodule

// File: src/trs_rot_build.sv
module trs_rot_build import trs_pkg::*; (
	input  logic clk,
	input  logic ld,
	input  s1_t  d,
	output s2_t  q
);

	s2_t  stg_s2;
	rot_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
	rot_t [N_ROT-1:0] rot;

	always_comb begin
		xx = ROT_W'(d.xx);
		yy = ROT_W'(d.yy);
		zz = ROT_W'(d.zz);
		xy = ROT_W'(d.xy);
		xz = ROT_W'(d.xz);
		yz = ROT_W'(d.yz);
		wx = ROT_W'(d.wx);
		wy = ROT_W'(d.wy);
		wz = ROT_W'(d.wz);
		rot[0] = ONE_Q28 - ((yy + zz) <<< 1);
		rot[1] = (xy - wz) <<< 1;
		rot[2] = (xz + wy) <<< 1;
		rot[3] = (xy + wz) <<< 1;
		rot[4] = ONE_Q28 - ((xx + zz) <<< 1);
		rot[5] = (yz - wx) <<< 1;
		rot[6] = (xz - wy) <<< 1;
		rot[7] = (yz + wx) <<< 1;
		rot[8] = ONE_Q28 - ((xx + yy) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			stg_s2.rot   <= rot;
			stg_s2.scale <= d.scale;
			stg_s2.shift <= d.shift;
		end
	end

	assign q = stg_s2;

endmodule

// File: src/trs_scale_round.sv
module trs_scale_round import trs_pkg::*; (
	input  logic      clk,
	input  logic      ld_s3,
	input  logic      ld_s4,
	input  s2_t       d,
	output out_beat_t q
);

	mul_t [N_ROT-1:0] mul_s3;
	sh_t [2:0]        shift_s3;
	mul_t [N_ROT-1:0] rnd;
	logic signed [N_ROT-1:0][OUT_W-1:0] ent;
	out_beat_t        res_s4;

	genvar k;
	generate
		for (k = 0; k < N_ROT; k++) begin : g_ent
			always_ff @(posedge clk) begin
				if (ld_s3) begin
					mul_s3[k] <= $signed(d.rot[k]) * $signed(d.scale[k % 3]);
				end
			end
			// round half up, floor shift to Q16.16
			assign rnd[k] = $signed(mul_s3[k]) + RND_HALF;
			assign ent[k] = {{(OUT_W - MUL_W + FRAC_DROP){rnd[k][MUL_W-1]}},
				rnd[k][MUL_W-1:FRAC_DROP]};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			shift_s3 <= d.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			res_s4.out_r0c0 <= ent[0];
			res_s4.out_r0c1 <= ent[1];
			res_s4.out_r0c2 <= ent[2];
			res_s4.out_r0c3 <= shift_s3[0];
			res_s4.out_r1c0 <= ent[3];
			res_s4.out_r1c1 <= ent[4];
			res_s4.out_r1c2 <= ent[5];
			res_s4.out_r1c3 <= shift_s3[1];
			res_s4.out_r2c0 <= ent[6];
			res_s4.out_r2c1 <= ent[7];
			res_s4.out_r2c2 <= ent[8];
			res_s4.out_r2c3 <= shift_s3[2];
		end
	end

	assign q = res_s4;

endmodule

// File: src/trs_compose_affine_matrix.sv
// Affine matrix composer: quaternion + per-axis scale + translation in,
// top three rows of the 4x4 affine matrix out (Q16.16, bottom row implied).
//
// Channels: item (sink) takes one beat with quat_x..w (Q2.14), scale_x..z
// (Q8.8) and shift_x..z (Q16.16). mtx (source) gives one beat of twelve
// entries out_rIcJ per input beat, in order. A beat moves when valid and
// ready are both high.
//
// Each beat passes through four register stages in order (quaternion
// products, rotation sums, scale multiply, rounding). Throughput: one beat
// per cycle while mtx.ready stays high, each stage taking a new beat every
// cycle.
//
// Stall: when mtx.ready is low, stages fill up behind the output register
// and bubbles collapse; item.ready drops only when all four stages hold a
// beat. Nothing is lost or repeated.
//
// Reset: arst_n clears the stage valid bits; the pipe is empty and ready.
module trs_compose_affine_matrix import trs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	trs_in_if.sink    item,
	trs_out_if.source mtx
);

	pipe_ld_t ld;
	s1_t      prod;
	s2_t      rotd;

	trs_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (mtx.valid),
		.out_ready (mtx.ready),
		.ld        (ld)
	);

	trs_quat_prod u_prod (
		.clk (clk),
		.ld  (ld.ld_s1),
		.d   (item.data),
		.q   (prod)
	);

	trs_rot_build u_rot (
		.clk (clk),
		.ld  (ld.ld_s2),
		.d   (prod),
		.q   (rotd)
	);

	trs_scale_round u_scl (
		.clk   (clk),
		.ld_s3 (ld.ld_s3),
		.ld_s4 (ld.ld_s4),
		.d     (rotd),
		.q     (mtx.data)
	);

endmodule

// File: dv/trs_compose_affine_matrix_test.sv
module trs_compose_affine_matrix_test;
	timeunit 1ns;
	timeprecision 1ps;

	import trs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 64;

	typedef logic [11:0][OUT_W-1:0] mtx_words_t;

	logic clk;
	logic arst_n;

	trs_in_if  item_ch ();
	trs_out_if mtx_ch ();

	trs_compose_affine_matrix DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.mtx    (mtx_ch)
	);

	mtx_words_t pending_mtx[$];
	int         mismatch_count = 0;
	int         beats_checked  = 0;
	int         src_idle_pct   = 0;
	int         sink_stall_pct = 0;
	int         hold_req       = 0;
	int         hold_left      = 0;
	int         idle_cycles    = 0;

	always #5 clk = ~clk;

	// Rotation in Q.28 from the doubled products, times the Q8.8 scale,
	// rounded half up to Q16.16; translation passes through.
	function automatic mtx_words_t compose_matrix(in_beat_t b);
		longint x, y, z, w, unit, acc;
		longint sc[3];
		longint rot[3][3];
		mtx_words_t m;
		int i, j;
		x = b.quat_x;
		y = b.quat_y;
		z = b.quat_z;
		w = b.quat_w;
		unit = 64'sd1 <<< 28;
		rot[0][0] = unit - 2 * (y * y + z * z);
		rot[0][1] = 2 * (x * y - w * z);
		rot[0][2] = 2 * (x * z + w * y);
		rot[1][0] = 2 * (x * y + w * z);
		rot[1][1] = unit - 2 * (x * x + z * z);
		rot[1][2] = 2 * (y * z - w * x);
		rot[2][0] = 2 * (x * z - w * y);
		rot[2][1] = 2 * (y * z + w * x);
		rot[2][2] = unit - 2 * (x * x + y * y);
		sc[0] = b.scale_x;
		sc[1] = b.scale_y;
		sc[2] = b.scale_z;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				acc = rot[i][j] * sc[j] + (64'sd1 <<< (FRAC_DROP - 1));
				m[11 - (4 * i + j)] = OUT_W'(acc >>> FRAC_DROP);
			end
		end
		m[8] = b.shift_x;
		m[4] = b.shift_y;
		m[0] = b.shift_z;
		return m;
	endfunction

	function automatic in_beat_t mk_beat(int qx, int qy, int qz, int qw,
		int sx, int sy, int sz, int tx, int ty, int tz);
		in_beat_t b;
		b.quat_x  = q_t'(qx);
		b.quat_y  = q_t'(qy);
		b.quat_z  = q_t'(qz);
		b.quat_w  = q_t'(qw);
		b.scale_x = q_t'(sx);
		b.scale_y = q_t'(sy);
		b.scale_z = q_t'(sz);
		b.shift_x = sh_t'(tx);
		b.shift_y = sh_t'(ty);
		b.shift_z = sh_t'(tz);
		return b;
	endfunction

	function automatic int pick16();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			4: return 1;
			5: return 16384;
			6: return -16384;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int pick32();
		case ($urandom_range(0, 5))
			0: return int'(32'h8000_0000);
			1: return int'(32'h7fff_ffff);
			2: return 0;
			3: return -1;
			4: return 1;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic int near_unit();
		return int'($urandom_range(0, 23170)) - 11585;
	endfunction

	function automatic in_beat_t random_beat();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 4)
			return mk_beat($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (mode < 7)
			return mk_beat(pick16(), pick16(), pick16(), pick16(),
				pick16(), pick16(), pick16(), pick32(), pick32(), pick32());
		return mk_beat(near_unit(), near_unit(), near_unit(), near_unit(),
			int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
			int'($urandom_range(0, 2047)) - 1024, $urandom, $urandom, $urandom);
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// entered and left at a falling edge
	task automatic send_beat(in_beat_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_mtx.push_back(compose_matrix(b));
		@(negedge clk);
	endtask

	task automatic set_idle(int src_pct, int sink_pct);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		repeat (n)
			send_beat(random_beat());
	endtask

	task automatic test_directed();
		set_idle(0, 0);
		send_beat(mk_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_beat(mk_beat(0, 0, 0, 16384, 256, 256, 256, 32'h0001_0000, -65536, 0));
		send_beat(mk_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send_beat(mk_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			int'(32'h8000_0000), int'(32'h8000_0000), int'(32'h8000_0000)));
		send_beat(mk_beat(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 1, -1, 0));
		send_beat(mk_beat(-32768, 0, 0, 0, -32768, -32768, -32768, -1, -1, -1));
		send_beat(mk_beat(0, 0, 11585, 11585, 256, 256, 256, 12345, -54321, 7));
		// rounding ties: positive and negative half-LSB products
		send_beat(mk_beat(16, 1, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_beat(mk_beat(16, 1, 0, 0, 0, -16384, 0, 0, 0, 0));
		send_beat(mk_beat(48, 1, 0, 0, 0, 16384, 0, 0, 0, 0));
		send_beat(mk_beat(48, 1, 0, 0, 0, -16384, 0, 0, 0, 0));
		// unnormalized quaternion, mixed signs
		send_beat(mk_beat(32767, -32768, 32767, -32768, -32768, 32767, -1,
			int'(32'h8000_0000), 32'h7fff_ffff, -1));
		send_beat(mk_beat(0, 0, 0, 16384, 1, -1, 1, 1, 0, -1));
		send_beat(mk_beat(8192, -8192, 8192, 8192, 512, -128, 1000, 3, -3, 65536));
	endtask

	task automatic test_no_idle();
		set_idle(0, 0);
		send_random(130);
	endtask

	task automatic test_source_gaps();
		set_idle(50, 0);
		send_random(130);
	endtask

	task automatic test_sink_stalls();
		set_idle(0, 50);
		send_random(130);
	endtask

	task automatic test_both_idle();
		set_idle(19, 19);
		send_random(130);
	endtask

	// long output hold-off while beats keep coming: pipe fills, input stalls
	task automatic test_backpressure();
		set_idle(0, 0);
		@(posedge clk);
		hold_req = HOLD_CYCLES;
		@(negedge clk);
		send_random(40);
	endtask

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			mtx_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			mtx_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		mtx_words_t got, want;
		int k;
		if (arst_n && mtx_ch.valid && mtx_ch.ready) begin
			if (pending_mtx.size() == 0) begin
				report_mismatch("matrix beat with nothing pending");
			end else begin
				got  = mtx_ch.data;
				want = pending_mtx.pop_front();
				for (k = 0; k < 12; k++) begin
					if (got[11 - k] !== want[11 - k])
						report_mismatch($sformatf("beat %0d out_r%0dc%0d: got %h want %h",
							beats_checked, k / 4, k % 4, got[11 - k], want[11 - k]));
				end
			end
			beats_checked++;
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (mtx_ch.valid && mtx_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d pending",
				idle_cycles, pending_mtx.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		mtx_ch.ready  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_no_idle();
		test_source_gaps();
		test_sink_stalls();
		test_both_idle();
		test_backpressure();

		item_ch.valid <= 1'b0;
		while (pending_mtx.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
